@@ hw/rtl/multiboot_upload_sequencer_assert.svh @@
// Assertion macros for the multiboot upload sequencer
`ifndef MULTIBOOT_UPLOAD_SEQUENCER_ASSERT_SVH
`define MULTIBOOT_UPLOAD_SEQUENCER_ASSERT_SVH

// cond at an edge implies expr at the same edge
`define MUS_ASSERT_IMPLIES(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// cond never holds at an edge
`define MUS_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

@@ hw/rtl/mus_pkg.sv @@
// Shared types, codes and CRC helpers for the multiboot upload sequencer
package mus_pkg;

  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_FETCHED = 2'd1;
  localparam logic [1:0] OP_REPLY   = 2'd2;

  localparam logic [1:0] ACT_FETCH = 2'd0;
  localparam logic [1:0] ACT_SEND  = 2'd1;
  localparam logic [1:0] ACT_DONE  = 2'd2;
  localparam logic [1:0] ACT_FAIL  = 2'd3;

  localparam logic [1:0] FAIL_NONE      = 2'd0;
  localparam logic [1:0] FAIL_HANDSHAKE = 2'd1;
  localparam logic [1:0] FAIL_TOKEN     = 2'd2;
  localparam logic [1:0] FAIL_READY     = 2'd3;

  localparam logic [18:0] MAX_IMAGE_BYTES = 19'd262144;
  localparam logic [18:0] MIN_IMAGE_BYTES = 19'd448;
  localparam logic [18:0] HEADER_BYTES    = 19'd192;
  localparam logic [18:0] COUNT_BIAS      = 19'h190;

  localparam logic [15:0] CRC_START = 16'hC387;
  localparam logic [15:0] CRC_POLY  = 16'hC37B;

  localparam logic [15:0] HS_REQ      = 16'h6202;
  localparam logic [15:0] HS_ACK_REQ  = 16'h6102;
  localparam logic [15:0] HS_REPLY    = 16'h7202;
  localparam logic [15:0] SYNC_WORD   = 16'h6200;
  localparam logic [15:0] TOKEN_WORD  = 16'h63D1;
  localparam logic [7:0]  TOKEN_TAG   = 8'h73;
  localparam logic [7:0]  CRCA_TAG    = 8'h64;
  localparam logic [7:0]  CRCA_BIAS   = 8'h0F;
  localparam logic [7:0]  SEED_LOW    = 8'hD1;
  localparam logic [15:0] READY_POLL  = 16'h0065;
  localparam logic [15:0] READY_REPLY = 16'h0075;
  localparam logic [15:0] CRC_CMD     = 16'h0066;

  localparam logic [31:0] SEED_MULT  = 32'h6F646573;
  localparam logic [31:0] MASK_BASE  = 32'hFE000000;
  localparam logic [31:0] MASK_XOR   = 32'h43202F2F;

  localparam logic [15:0] RETRY_RESET = 16'd8000;

  localparam logic CFG_IMAGE_BYTES = 1'b0;
  localparam logic CFG_RETRY_LIMIT = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] image_word;
    logic [31:0] reply_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [17:0] fetch_offset;
    logic [31:0] send_word;
    logic [1:0]  fail_code;
  } out_item_t;

  typedef struct packed {
    logic       space;
    logic [1:0] count;
  } fifo_status_t;

  // Bit-serial fold, LSB first; only ever called with constant arguments
  function automatic logic [15:0] crc_fold_serial(logic [15:0] crc, logic [31:0] w);
    logic [15:0] c;
    logic [31:0] d;
    c = crc;
    d = w;
    for (int b = 0; b < 32; b++) begin
      if (c[0] ^ d[0]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
      d = d >> 1;
    end
    return c;
  endfunction

  // The fold is linear over GF(2): XOR the constant column of every set bit
  function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [31:0] w);
    logic [15:0] acc;
    acc = '0;
    for (int i = 0; i < 16; i++)
      if (crc[i]) acc = acc ^ crc_fold_serial(16'(1) << i, 32'd0);
    for (int j = 0; j < 32; j++)
      if (w[j]) acc = acc ^ crc_fold_serial(16'd0, 32'(1) << j);
    return acc;
  endfunction

endpackage

@@ hw/rtl/mus_stream_if.sv @@
// Valid/ready stream channel carrying one payload struct
interface mus_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/mus_in_stage.sv @@
// Input register holding one accepted item until the engine takes it
module mus_in_stage (
  input  logic             clk,
  input  logic             rst,
  mus_stream_if.sink       cmd,
  input  logic             advance,
  output logic             held_valid,
  output mus_pkg::in_item_t held
);

  assign cmd.ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      held <= cmd.payload;
    end
  end

endmodule

@@ hw/rtl/mus_engine.sv @@
// Sequencer state, configuration registers and the per-item step logic
module mus_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [18:0]       cfg_data,
  input  logic              advance,
  input  mus_pkg::in_item_t item,
  output logic              has_result,
  output mus_pkg::out_item_t result
);

  localparam logic [4:0] PH_IDLE        = 5'd0;
  localparam logic [4:0] PH_CRC_FETCH   = 5'd1;
  localparam logic [4:0] PH_HS          = 5'd2;
  localparam logic [4:0] PH_HS_ACK      = 5'd3;
  localparam logic [4:0] PH_HDR_FETCH   = 5'd4;
  localparam logic [4:0] PH_HDR_LO      = 5'd5;
  localparam logic [4:0] PH_HDR_HI      = 5'd6;
  localparam logic [4:0] PH_SYNC_A      = 5'd7;
  localparam logic [4:0] PH_SYNC_B      = 5'd8;
  localparam logic [4:0] PH_TOKEN_A     = 5'd9;
  localparam logic [4:0] PH_TOKEN_B     = 5'd10;
  localparam logic [4:0] PH_CRCA_SENT   = 5'd11;
  localparam logic [4:0] PH_COUNT_SENT  = 5'd12;
  localparam logic [4:0] PH_PAY_FETCH   = 5'd13;
  localparam logic [4:0] PH_PAY_SENT    = 5'd14;
  localparam logic [4:0] PH_READY_FIRST = 5'd15;
  localparam logic [4:0] PH_READY_POLL  = 5'd16;
  localparam logic [4:0] PH_SENT_66     = 5'd17;
  localparam logic [4:0] PH_SENT_CRC    = 5'd18;

  logic [18:0] image_bytes;
  logic [15:0] retry_limit;

  logic [4:0]  phase, phase_next;
  logic [15:0] running_crc, running_crc_next;
  logic [31:0] scramble_seed, scramble_seed_next;
  logic [7:0]  token_crc_a, token_crc_a_next;
  logic [7:0]  token_crc_b, token_crc_b_next;
  logic [15:0] word_counter, word_counter_next;
  logic [15:0] attempt_count, attempt_count_next;
  logic [15:0] held_halfword, held_halfword_next;

  logic [18:0] size_raw;
  logic [18:0] size;
  logic [18:0] count_diff;
  logic [15:0] wc_inc;
  logic [18:0] off_inc;
  logic [18:0] off_now;
  logic [17:0] hdr_off;
  logic [31:0] seed_prod;
  logic [31:0] seed_step;
  logic [31:0] pay_word;
  logic [15:0] crc_image;
  logic [15:0] crc_final;
  logic [7:0]  token_a;
  logic [7:0]  crca_next;
  logic        retries_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_bytes <= mus_pkg::MAX_IMAGE_BYTES;
      retry_limit <= mus_pkg::RETRY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mus_pkg::CFG_IMAGE_BYTES: image_bytes <= cfg_data;
        mus_pkg::CFG_RETRY_LIMIT: retry_limit <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Drop the low two bits, then clamp to the legal image range
  always_comb begin
    size_raw = {image_bytes[18:2], 2'b00};
    if (size_raw > mus_pkg::MAX_IMAGE_BYTES) size = mus_pkg::MAX_IMAGE_BYTES;
    else if (size_raw < mus_pkg::MIN_IMAGE_BYTES) size = mus_pkg::MIN_IMAGE_BYTES;
    else size = size_raw;
  end

  assign count_diff  = size - mus_pkg::COUNT_BIAS;
  assign wc_inc      = word_counter + 16'd1;
  assign off_inc     = mus_pkg::HEADER_BYTES + {1'b0, wc_inc, 2'b00};
  assign off_now     = mus_pkg::HEADER_BYTES + {1'b0, word_counter, 2'b00};
  assign hdr_off     = {wc_inc, 2'b00};
  assign seed_prod   = scramble_seed * mus_pkg::SEED_MULT;
  assign seed_step   = seed_prod + 32'd1;
  assign pay_word    = item.image_word ^ (mus_pkg::MASK_BASE - {13'd0, off_now})
                       ^ mus_pkg::MASK_XOR;
  assign crc_image   = mus_pkg::crc_fold(running_crc, item.image_word);
  assign crc_final   = mus_pkg::crc_fold(running_crc,
                                         {16'hFFFF, token_crc_b, token_crc_a});
  assign token_a     = item.reply_word[23:16];
  assign crca_next   = token_a + mus_pkg::CRCA_BIAS;
  assign retries_out = attempt_count >= retry_limit;

  always_comb begin
    phase_next         = phase;
    running_crc_next   = running_crc;
    scramble_seed_next = scramble_seed;
    token_crc_a_next   = token_crc_a;
    token_crc_b_next   = token_crc_b;
    word_counter_next  = word_counter;
    attempt_count_next = attempt_count;
    held_halfword_next = held_halfword;
    has_result         = 1'b0;
    result             = '0;

    unique case (item.operation)
      mus_pkg::OP_START: begin
        running_crc_next    = mus_pkg::CRC_START;
        scramble_seed_next  = '0;
        token_crc_a_next    = '0;
        token_crc_b_next    = '0;
        word_counter_next   = '0;
        attempt_count_next  = '0;
        held_halfword_next  = '0;
        phase_next          = PH_CRC_FETCH;
        has_result          = 1'b1;
        result.action       = mus_pkg::ACT_FETCH;
        result.fetch_offset = mus_pkg::HEADER_BYTES[17:0];
      end
      mus_pkg::OP_FETCHED: begin
        unique case (phase)
          PH_CRC_FETCH: begin
            running_crc_next  = crc_image;
            word_counter_next = wc_inc;
            has_result        = 1'b1;
            if (off_inc < size) begin
              result.action       = mus_pkg::ACT_FETCH;
              result.fetch_offset = off_inc[17:0];
            end else begin
              attempt_count_next = '0;
              phase_next         = PH_HS;
              result.action      = mus_pkg::ACT_SEND;
              result.send_word   = {16'd0, mus_pkg::HS_REQ};
            end
          end
          PH_HDR_FETCH: begin
            held_halfword_next = item.image_word[31:16];
            phase_next         = PH_HDR_LO;
            has_result         = 1'b1;
            result.action      = mus_pkg::ACT_SEND;
            result.send_word   = {16'd0, item.image_word[15:0]};
          end
          PH_PAY_FETCH: begin
            scramble_seed_next = seed_step;
            phase_next         = PH_PAY_SENT;
            has_result         = 1'b1;
            result.action      = mus_pkg::ACT_SEND;
            result.send_word   = pay_word ^ seed_step;
          end
          default: ;
        endcase
      end
      mus_pkg::OP_REPLY: begin
        has_result    = 1'b1;
        result.action = mus_pkg::ACT_SEND;
        unique case (phase)
          PH_HS: begin
            if (retries_out) begin
              phase_next       = PH_IDLE;
              result.action    = mus_pkg::ACT_FAIL;
              result.fail_code = mus_pkg::FAIL_HANDSHAKE;
            end else begin
              attempt_count_next = attempt_count + 16'd1;
              if (item.reply_word[31:16] == mus_pkg::HS_REPLY) begin
                phase_next       = PH_HS_ACK;
                result.send_word = {16'd0, mus_pkg::HS_ACK_REQ};
              end else begin
                result.send_word = {16'd0, mus_pkg::HS_REQ};
              end
            end
          end
          PH_HS_ACK: begin
            word_counter_next = '0;
            phase_next        = PH_HDR_FETCH;
            result.action     = mus_pkg::ACT_FETCH;
          end
          PH_HDR_LO: begin
            phase_next       = PH_HDR_HI;
            result.send_word = {16'd0, held_halfword};
          end
          PH_HDR_HI: begin
            word_counter_next = wc_inc;
            if (hdr_off < mus_pkg::HEADER_BYTES[17:0]) begin
              phase_next          = PH_HDR_FETCH;
              result.action       = mus_pkg::ACT_FETCH;
              result.fetch_offset = hdr_off;
            end else begin
              phase_next       = PH_SYNC_A;
              result.send_word = {16'd0, mus_pkg::SYNC_WORD};
            end
          end
          PH_SYNC_A: begin
            phase_next       = PH_SYNC_B;
            result.send_word = {16'd0, mus_pkg::SYNC_WORD};
          end
          PH_SYNC_B: begin
            phase_next       = PH_TOKEN_A;
            result.send_word = {16'd0, mus_pkg::TOKEN_WORD};
          end
          PH_TOKEN_A: begin
            phase_next       = PH_TOKEN_B;
            result.send_word = {16'd0, mus_pkg::TOKEN_WORD};
          end
          PH_TOKEN_B: begin
            if (item.reply_word[31:24] != mus_pkg::TOKEN_TAG) begin
              phase_next       = PH_IDLE;
              result.action    = mus_pkg::ACT_FAIL;
              result.fail_code = mus_pkg::FAIL_TOKEN;
            end else begin
              scramble_seed_next = {16'hFFFF, token_a, mus_pkg::SEED_LOW};
              token_crc_a_next   = crca_next;
              phase_next         = PH_CRCA_SENT;
              result.send_word   = {16'd0, mus_pkg::CRCA_TAG, crca_next};
            end
          end
          PH_CRCA_SENT: begin
            phase_next       = PH_COUNT_SENT;
            result.send_word = {15'd0, count_diff[18:2]};
          end
          PH_COUNT_SENT: begin
            token_crc_b_next    = item.reply_word[23:16];
            word_counter_next   = '0;
            phase_next          = PH_PAY_FETCH;
            result.action       = mus_pkg::ACT_FETCH;
            result.fetch_offset = mus_pkg::HEADER_BYTES[17:0];
          end
          PH_PAY_SENT: begin
            word_counter_next = wc_inc;
            if (off_inc < size) begin
              phase_next          = PH_PAY_FETCH;
              result.action       = mus_pkg::ACT_FETCH;
              result.fetch_offset = off_inc[17:0];
            end else begin
              running_crc_next   = crc_final;
              attempt_count_next = '0;
              phase_next         = PH_READY_FIRST;
              result.send_word   = {16'd0, mus_pkg::READY_POLL};
            end
          end
          PH_READY_FIRST: begin
            phase_next       = PH_READY_POLL;
            result.send_word = {16'd0, mus_pkg::READY_POLL};
          end
          PH_READY_POLL: begin
            if (retries_out) begin
              phase_next       = PH_IDLE;
              result.action    = mus_pkg::ACT_FAIL;
              result.fail_code = mus_pkg::FAIL_READY;
            end else begin
              attempt_count_next = attempt_count + 16'd1;
              if (item.reply_word[31:16] == mus_pkg::READY_REPLY) begin
                phase_next       = PH_SENT_66;
                result.send_word = {16'd0, mus_pkg::CRC_CMD};
              end else begin
                result.send_word = {16'd0, mus_pkg::READY_POLL};
              end
            end
          end
          PH_SENT_66: begin
            phase_next       = PH_SENT_CRC;
            result.send_word = {16'd0, running_crc};
          end
          PH_SENT_CRC: begin
            phase_next    = PH_IDLE;
            result.action = mus_pkg::ACT_DONE;
          end
          default: begin
            has_result    = 1'b0;
            result.action = mus_pkg::ACT_FETCH;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      running_crc   <= mus_pkg::CRC_START;
      scramble_seed <= '0;
      token_crc_a   <= '0;
      token_crc_b   <= '0;
      word_counter  <= '0;
      attempt_count <= '0;
      held_halfword <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      running_crc   <= running_crc_next;
      scramble_seed <= scramble_seed_next;
      token_crc_a   <= token_crc_a_next;
      token_crc_b   <= token_crc_b_next;
      word_counter  <= word_counter_next;
      attempt_count <= attempt_count_next;
      held_halfword <= held_halfword_next;
    end
  end

endmodule

@@ hw/rtl/mus_out_fifo.sv @@
// Two-entry circular result buffer with separate read and write pointers
module mus_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mus_pkg::out_item_t push_item,
  mus_stream_if.source       res,
  output mus_pkg::fifo_status_t status
);

  mus_pkg::out_item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop           = res.valid && res.ready;
  assign res.valid     = count != 2'd0;
  assign res.payload   = slots[rd_ptr];
  assign status.space  = count != 2'd2;
  assign status.count  = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

@@ hw/rtl/multiboot_upload_sequencer.sv @@
// Top level of the multiboot upload sequencer
//
//   channel  | dir | payload                                          | transfer
//   ---------+-----+--------------------------------------------------+----------------
//   cmd      | in  | operation, image_word, reply_word                | valid && ready
//   res      | out | action, fetch_offset, send_word, fail_code       | valid && ready
//   cfg      | in  | cfg_index, cfg_data (image_bytes, retry_limit)   | cfg_write
//
// One item per cycle sustained while res does not stall: the step logic between the
// input register and the result buffer is combinational and updates the state on each advance.
// An item is registered in the input register, and its result is then written into
// the result buffer, from which it is offered on res.
// Synchronous active-high reset returns to idle with the default registers.
// A stall on res fills the two-entry result buffer; cmd then holds ready low
// once both the buffer and the input register are full.
module multiboot_upload_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [18:0] cfg_data,
  mus_stream_if.sink   cmd,
  mus_stream_if.source res
);

  `include "multiboot_upload_sequencer_assert.svh"

  logic                  held_valid;
  mus_pkg::in_item_t     held;
  logic                  advance;
  logic                  has_result;
  logic                  push;
  mus_pkg::out_item_t    result;
  mus_pkg::fifo_status_t fifo_status;
  logic                  pipe_full;
  logic                  start_taken;
  logic                  start_fetch_ok;

  // Process the held item only when the result buffer can take its output
  assign advance = held_valid && fifo_status.space;
  assign push    = advance && has_result;

  assign pipe_full      = held_valid && !fifo_status.space;
  assign start_taken    = advance && held.operation == mus_pkg::OP_START;
  assign start_fetch_ok = push && result.action == mus_pkg::ACT_FETCH &&
                          result.fetch_offset == mus_pkg::HEADER_BYTES[17:0];

  mus_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .advance    (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  mus_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .advance    (advance),
    .item       (held),
    .has_result (has_result),
    .result     (result)
  );

  mus_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (result),
    .res       (res),
    .status    (fifo_status)
  );

  `MUS_ASSERT_NEVER(a_no_overflow, clk, rst, push && !fifo_status.space, "result buffer overflow")

  `MUS_ASSERT_IMPLIES(a_stall_cause, clk, rst, !cmd.ready, pipe_full, "cmd stalled while not full")

  `MUS_ASSERT_IMPLIES(a_start_fetch, clk, rst, start_taken, start_fetch_ok, "bad start fetch")

endmodule
